FILE: hdl/snbe_pkg.sv
// shared types, constants and the header checksum function of the source nat binding engine
// used by every file of the block, no dependencies

package snbe_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int RECLAIM_DEPTH_DEF = 16;

    localparam logic [15:0] DF_BIT = 16'h4000;
    localparam logic [47:0] TIMEOUT_RST = 48'd7200000000000;

    localparam logic [1:0] REG_PREFIX  = 2'd0;
    localparam logic [1:0] REG_MASK    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic [1:0] VERDICT_PASS     = 2'd0;
    localparam logic [1:0] VERDICT_REWRITE  = 2'd1;
    localparam logic [1:0] VERDICT_REDIRECT = 2'd2;
    localparam logic [1:0] VERDICT_DROP     = 2'd3;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [31:0] data;
    } t_fifo_req;

    typedef struct packed {
        logic        empty;
        logic [31:0] head;
    } t_fifo_stat;

    // ones-complement header checksum over the ten header words
    function automatic logic [15:0] hdr_csum(
        input logic [3:0]  ihl,
        input logic [7:0]  tos,
        input logic [15:0] tlen,
        input logic [15:0] id,
        input logic [15:0] frag,
        input logic [7:0]  ttl,
        input logic [7:0]  proto,
        input logic [31:0] src,
        input logic [31:0] dst
    );
        logic [19:0] s;
        logic [16:0] f;
        logic [16:0] g;
        s = {8'h04, ihl, tos} + {4'h0, tlen} + {4'h0, id} + {4'h0, frag}
            + {4'h0, ttl, proto} + {4'h0, src[31:16]} + {4'h0, src[15:0]}
            + {4'h0, dst[31:16]} + {4'h0, dst[15:0]};
        f = {1'b0, s[15:0]} + {13'h0, s[19:16]};
        g = {1'b0, f[15:0]} + {16'h0, f[16]};
        return ~g[15:0];
    endfunction

endpackage

FILE: hdl/snbe_fifo.sv
// reclaim queue of public addresses: circular buffer in a memory, head read registered
// depends on snbe_pkg

module snbe_fifo #(
    parameter int RECLAIM_DEPTH = snbe_pkg::RECLAIM_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  snbe_pkg::t_fifo_req  i_req,
    output snbe_pkg::t_fifo_stat o_stat
);
    localparam int PW = (RECLAIM_DEPTH > 1) ? $clog2(RECLAIM_DEPTH) : 1;
    localparam int CW = $clog2(RECLAIM_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RECLAIM_DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(RECLAIM_DEPTH - 1);

    logic [31:0]   mem [RECLAIM_DEPTH];
    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_head_q;
    logic [PW:0]   tail_sum;
    logic [PW-1:0] tail;

    // tail = head + count, wrapped at the depth
    always_comb begin
        tail_sum = {1'b0, r_head} + (PW+1)'(r_count);
        if (tail_sum >= (PW+1)'(RECLAIM_DEPTH)) begin
            tail = PW'(tail_sum - (PW+1)'(RECLAIM_DEPTH));
        end else begin
            tail = tail_sum[PW-1:0];
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_req.pop && (r_count != '0)) begin
            n_head  = (r_head == LAST_C) ? '0 : r_head + PW'(1);
            n_count = r_count - CW'(1);
        end else if (i_req.push && (r_count < DEPTH_C)) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push && !i_req.pop && (r_count < DEPTH_C)) begin
            mem[tail] <= i_req.data;
        end
        r_head_q <= mem[r_head];
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_head_q;

endmodule

FILE: hdl/source_nat_binding_engine.sv
// top level of the source nat binding engine: sequencer, binding store and result register
// depends on snbe_pkg and snbe_fifo

// One IPv4 header is taken per transfer and gives exactly one result. The block
// handles one header at a time: o_in_ready is high only while the sequencer is idle.
// A header is walked through a single compare unit that visits one binding per cycle
// from a memory with registered read, so the cost is set by table passes:
// a bypassed header needs no pass, a lookup takes one pass over the table, a new
// binding adds an allocation step and one more pass, plus up to one pass for an
// eviction when the pool and the reclaim queue are both used up, so three passes at most.
// A new header can be taken while the previous result still waits in the output register.

module source_nat_binding_engine #(
    parameter int TABLE_ENTRIES = snbe_pkg::TABLE_ENTRIES_DEF,
    parameter int RECLAIM_DEPTH = snbe_pkg::RECLAIM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // header channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [3:0]  i_hdr_words,
    input  logic [15:0] i_frag_field,
    input  logic [15:0] i_ident,
    input  logic [7:0]  i_proto_num,
    input  logic [7:0]  i_ttl_val,
    input  logic [7:0]  i_tos_val,
    input  logic [15:0] i_total_length,
    input  logic [63:0] i_now_ns,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_out_src,
    output logic [31:0] o_out_dst,
    output logic [15:0] o_out_ident,
    output logic [15:0] o_out_frag,
    output logic [15:0] o_out_checksum
);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOOK  = 6'b000010,
        S_ALLOC = 6'b000100,
        S_EVICT = 6'b001000,
        S_FREE  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [31:0] r_prefix, r_mask;
    logic [47:0] r_timeout;

    // latched header
    logic        r_kind;
    logic [31:0] r_src, r_dst;
    logic [3:0]  r_ihl;
    logic [15:0] r_frag, r_id, r_tlen;
    logic [7:0]  r_proto, r_ttl, r_tos;
    logic [63:0] r_now;

    // binding store, entries readable only where the valid bit is set
    logic [31:0] mem_inside [TABLE_ENTRIES];
    logic [31:0] mem_public [TABLE_ENTRIES];
    logic [63:0] mem_seen   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [31:0] r_rd_inside, r_rd_public;
    logic [63:0] r_rd_seen;

    // scan control: r_idx is the address issued, r_chk_idx the entry compared
    logic [CW-1:0] r_idx, n_idx;
    logic          r_chk, n_chk;
    logic [AW-1:0] r_chk_idx, n_chk_idx;
    logic          scan_end;
    logic          chk_valid;

    // allocation state
    logic [31:0] r_next, n_next;
    logic [31:0] r_got, n_got;
    logic [63:0] r_cutoff, n_cutoff;
    logic [AW-1:0] r_slot, n_slot;
    logic        r_found, n_found;
    logic        r_clash, n_clash;
    logic [31:0] limit, cand;

    // pending result
    logic [1:0]  r_res_v, n_res_v;
    logic [31:0] r_res_src, n_res_src, r_res_dst, n_res_dst;
    logic [15:0] r_res_id, n_res_id, r_res_frag, n_res_frag;
    logic        r_res_cs, n_res_cs;

    // output register
    logic        r_ov;
    logic [1:0]  r_o_v;
    logic [31:0] r_o_src, r_o_dst;
    logic [15:0] r_o_id, r_o_frag, r_o_cs;

    // memory write port
    logic          we_seen, we_bind;
    logic [AW-1:0] waddr;

    snbe_pkg::t_fifo_req  fifo_req;
    snbe_pkg::t_fifo_stat fifo_stat;

    logic in_xfer, plain_in, out_free;

    snbe_fifo #(
        .RECLAIM_DEPTH(RECLAIM_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (fifo_req),
        .o_stat (fifo_stat)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign plain_in   = (i_hdr_words == 4'd5) && ((i_frag_field & ~snbe_pkg::DF_BIT) == 16'h0);
    assign out_free   = !r_ov || i_out_ready;

    assign limit     = (r_prefix | ~r_mask) - 32'd1;
    assign cand      = r_prefix + r_next;
    assign scan_end  = !r_chk && (r_idx == ENTRIES_C);
    assign chk_valid = r_valid[r_chk_idx];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_idx      = r_idx;
        n_chk      = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_next     = r_next;
        n_got      = r_got;
        n_cutoff   = r_cutoff;
        n_slot     = r_slot;
        n_found    = r_found;
        n_clash    = r_clash;
        n_res_v    = r_res_v;
        n_res_src  = r_res_src;
        n_res_dst  = r_res_dst;
        n_res_id   = r_res_id;
        n_res_frag = r_res_frag;
        n_res_cs   = r_res_cs;
        we_seen    = 1'b0;
        we_bind    = 1'b0;
        waddr      = r_chk_idx;
        fifo_req   = '{push: 1'b0, pop: 1'b0, data: r_got};

        // shared scan address stepping
        if (r_idx < ENTRIES_C) begin
            n_idx     = r_idx + CW'(1);
            n_chk     = 1'b1;
            n_chk_idx = r_idx[AW-1:0];
        end

        case (r_state)
            S_IDLE: begin
                n_idx      = '0;
                n_res_v    = snbe_pkg::VERDICT_PASS;
                n_res_src  = i_src_addr;
                n_res_dst  = i_dst_addr;
                n_res_id   = i_ident;
                n_res_frag = i_frag_field;
                n_res_cs   = 1'b0;
                if (in_xfer) begin
                    if (!i_kind) begin
                        n_state = plain_in ? S_LOOK : S_DONE;
                    end else if ((i_dst_addr & r_mask) != r_prefix) begin
                        n_state = S_DONE;
                    end else begin
                        // inbound inside the pool: drop unless a binding turns up
                        n_res_v    = snbe_pkg::VERDICT_DROP;
                        n_res_src  = '0;
                        n_res_dst  = '0;
                        n_res_id   = '0;
                        n_res_frag = '0;
                        n_state    = plain_in ? S_LOOK : S_DONE;
                    end
                end
            end
            S_LOOK: begin
                if (r_chk && chk_valid && !r_kind && (r_rd_inside == r_src)) begin
                    // outbound hit, refresh timestamp
                    we_seen    = 1'b1;
                    n_res_v    = snbe_pkg::VERDICT_REWRITE;
                    n_res_src  = r_rd_public;
                    n_res_id   = '0;
                    n_res_frag = snbe_pkg::DF_BIT;
                    n_res_cs   = 1'b1;
                    n_state    = S_DONE;
                end else if (r_chk && chk_valid && r_kind && (r_rd_public == r_dst)) begin
                    n_res_v    = snbe_pkg::VERDICT_REDIRECT;
                    n_res_src  = r_src;
                    n_res_dst  = r_rd_inside;
                    n_res_id   = r_id;
                    n_res_frag = r_frag;
                    n_res_cs   = 1'b1;
                    n_state    = S_DONE;
                end else if (scan_end) begin
                    n_state = r_kind ? S_DONE : S_ALLOC;
                end
            end
            S_ALLOC: begin
                n_idx    = '0;
                n_found  = 1'b0;
                n_clash  = 1'b0;
                n_cutoff = r_now - {16'h0, r_timeout};
                if (cand < limit) begin
                    n_next  = r_next + 32'd1;
                    n_got   = cand;
                    n_state = (cand == 32'd0) ? S_DONE : S_FREE;
                end else if (!fifo_stat.empty) begin
                    fifo_req.pop = 1'b1;
                    n_got   = fifo_stat.head;
                    n_state = (fifo_stat.head == 32'd0) ? S_DONE : S_FREE;
                end else begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                // the evicted address would go through the empty queue and straight back out
                if (r_chk && chk_valid && (r_rd_seen < r_cutoff)) begin
                    n_valid[r_chk_idx] = 1'b0;
                    n_got   = r_rd_public;
                    n_idx   = '0;
                    n_chk   = 1'b0;
                    n_state = (r_rd_public == 32'd0) ? S_DONE : S_FREE;
                end else if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                if (r_chk) begin
                    if (!chk_valid) begin
                        if (!r_found) begin
                            n_found = 1'b1;
                            n_slot  = r_chk_idx;
                        end
                    end else if (r_rd_public == r_got) begin
                        n_clash = 1'b1;
                    end
                end
                if (scan_end) begin
                    if (!r_found || r_clash) begin
                        fifo_req.push = 1'b1;
                    end else begin
                        we_bind          = 1'b1;
                        waddr            = r_slot;
                        n_valid[r_slot]  = 1'b1;
                        n_res_v          = snbe_pkg::VERDICT_REWRITE;
                        n_res_src        = r_got;
                        n_res_id         = '0;
                        n_res_frag       = snbe_pkg::DF_BIT;
                        n_res_cs         = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_next    <= 32'd1;
            r_idx     <= '0;
            r_chk     <= 1'b0;
            r_ov      <= 1'b0;
            r_prefix  <= '0;
            r_mask    <= '0;
            r_timeout <= snbe_pkg::TIMEOUT_RST;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_next  <= n_next;
            r_idx   <= n_idx;
            r_chk   <= n_chk;
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    snbe_pkg::REG_PREFIX:  r_prefix  <= i_cfg_data[31:0];
                    snbe_pkg::REG_MASK:    r_mask    <= i_cfg_data[31:0];
                    snbe_pkg::REG_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_chk_idx  <= n_chk_idx;
        r_got      <= n_got;
        r_cutoff   <= n_cutoff;
        r_slot     <= n_slot;
        r_found    <= n_found;
        r_clash    <= n_clash;
        r_res_v    <= n_res_v;
        r_res_src  <= n_res_src;
        r_res_dst  <= n_res_dst;
        r_res_id   <= n_res_id;
        r_res_frag <= n_res_frag;
        r_res_cs   <= n_res_cs;
        if (in_xfer) begin
            r_kind  <= i_kind;
            r_src   <= i_src_addr;
            r_dst   <= i_dst_addr;
            r_ihl   <= i_hdr_words;
            r_frag  <= i_frag_field;
            r_id    <= i_ident;
            r_proto <= i_proto_num;
            r_ttl   <= i_ttl_val;
            r_tos   <= i_tos_val;
            r_tlen  <= i_total_length;
            r_now   <= i_now_ns;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_v    <= r_res_v;
            r_o_src  <= r_res_src;
            r_o_dst  <= r_res_dst;
            r_o_id   <= r_res_id;
            r_o_frag <= r_res_frag;
            // rewritten headers are always plain, so the latched ihl is five
            r_o_cs   <= r_res_cs ? snbe_pkg::hdr_csum(r_ihl, r_tos, r_tlen, r_res_id,
                                                      r_res_frag, r_ttl, r_proto,
                                                      r_res_src, r_res_dst) : 16'h0;
        end
    end

    // binding store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we_seen || we_bind) begin
            mem_seen[waddr] <= r_now;
        end
        if (we_bind) begin
            mem_inside[waddr] <= r_src;
            mem_public[waddr] <= r_got;
        end
        r_rd_inside <= mem_inside[r_idx[AW-1:0]];
        r_rd_public <= mem_public[r_idx[AW-1:0]];
        r_rd_seen   <= mem_seen[r_idx[AW-1:0]];
    end

    assign o_out_valid    = r_ov;
    assign o_verdict      = r_o_v;
    assign o_out_src      = r_o_src;
    assign o_out_dst      = r_o_dst;
    assign o_out_ident    = r_o_id;
    assign o_out_frag     = r_o_frag;
    assign o_out_checksum = r_o_cs;

endmodule

FILE: hdl/snbe_checker.sv
// port-level checks of the source nat binding engine, bound to the top level
// depends on snbe_pkg and source_nat_binding_engine

module snbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_verdict,
    input logic [31:0] o_out_src,
    input logic [31:0] o_out_dst,
    input logic [15:0] o_out_ident,
    input logic [15:0] o_out_frag,
    input logic [15:0] o_out_checksum
);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict)
            && $stable(o_out_src) && $stable(o_out_checksum))
        else $error("result changed while stalled");

    // one header at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("header taken while busy");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == snbe_pkg::VERDICT_DROP) |->
            (o_out_src == '0) && (o_out_dst == '0) && (o_out_ident == '0)
            && (o_out_frag == '0) && (o_out_checksum == '0))
        else $error("drop result not cleared");

    a_rebuilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == snbe_pkg::VERDICT_REWRITE) |->
            (o_out_ident == '0) && (o_out_frag == snbe_pkg::DF_BIT))
        else $error("rebuilt header fields wrong");

endmodule

bind source_nat_binding_engine snbe_checker u_snbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_verdict     (o_verdict),
    .o_out_src     (o_out_src),
    .o_out_dst     (o_out_dst),
    .o_out_ident   (o_out_ident),
    .o_out_frag    (o_out_frag),
    .o_out_checksum(o_out_checksum)
);

FILE: tb/snbe_checker.sv
`timescale 1ns / 1ps
// checker of the source nat binding engine: predicts every result from the header transfers
// and compares it with the result transfers; depends on snbe_pkg

module snbe_tb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [3:0]  i_hdr_words,
    input  logic [15:0] i_frag_field,
    input  logic [15:0] i_ident,
    input  logic [7:0]  i_proto_num,
    input  logic [7:0]  i_ttl_val,
    input  logic [7:0]  i_tos_val,
    input  logic [15:0] i_total_length,
    input  logic [63:0] i_now_ns,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_verdict,
    input  logic [31:0] i_out_src,
    input  logic [31:0] i_out_dst,
    input  logic [15:0] i_out_ident,
    input  logic [15:0] i_out_frag,
    input  logic [15:0] i_out_checksum,
    output int          o_errors,
    output int          o_pending
);
    localparam int NBIND = snbe_pkg::TABLE_ENTRIES_DEF;
    localparam int NRECL = snbe_pkg::RECLAIM_DEPTH_DEF;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] ident;
        logic [15:0] frag;
        logic [15:0] csum;
    } t_result;

    logic [31:0] m_prefix, m_mask;
    logic [47:0] m_timeout;
    logic [31:0] b_inside [NBIND];
    logic [31:0] b_public [NBIND];
    logic [63:0] b_seen [NBIND];
    logic        b_valid [NBIND];
    logic [31:0] recl_q [$];
    logic [31:0] next_off;
    t_result     expected_results [$];

    function automatic logic [15:0] calc_csum(logic [3:0] ihl, logic [7:0] tos,
            logic [15:0] tlen, logic [15:0] id, logic [15:0] frag, logic [7:0] ttl,
            logic [7:0] proto, logic [31:0] src, logic [31:0] dst);
        logic [31:0] s;
        s = {16'h0, 4'h4, ihl, tos} + {16'h0, tlen} + {16'h0, id} + {16'h0, frag}
            + {16'h0, ttl, proto} + {16'h0, src[31:16]} + {16'h0, src[15:0]}
            + {16'h0, dst[31:16]} + {16'h0, dst[15:0]};
        s = (s >> 16) + (s & 32'hffff);
        s = s + (s >> 16);
        return ~s[15:0];
    endfunction

    function automatic void recl_push(logic [31:0] a);
        if (recl_q.size() < NRECL) recl_q.push_back(a);
    endfunction

    // reclaim queue first, then evict the first stale binding
    function automatic logic [31:0] reclaim(logic [63:0] now);
        logic [63:0] cutoff;
        cutoff = now - {16'h0, m_timeout};
        if (recl_q.size() > 0) return recl_q.pop_front();
        for (int i = 0; i < NBIND; i++) begin
            if (b_valid[i] && b_seen[i] < cutoff) begin
                b_valid[i] = 1'b0;
                recl_push(b_public[i]);
                break;
            end
        end
        if (recl_q.size() > 0) return recl_q.pop_front();
        return 32'h0;
    endfunction

    function automatic bit bind_new(logic [31:0] in_addr, logic [63:0] now,
            output logic [31:0] pub);
        logic [31:0] lim, cand, got;
        int slot;
        bit clash;
        lim = (m_prefix | ~m_mask) - 32'd1;
        cand = m_prefix + next_off;
        slot = NBIND;
        clash = 0;
        pub = 32'h0;
        if (cand >= lim) got = reclaim(now);
        else begin
            next_off = next_off + 32'd1;
            got = cand;
        end
        if (got == 32'h0) return 0;
        for (int i = 0; i < NBIND; i++) begin
            if (!b_valid[i]) begin
                if (slot == NBIND) slot = i;
            end else if (b_public[i] == got) clash = 1;
        end
        if (slot >= NBIND || clash) begin
            recl_push(got);
            return 0;
        end
        b_inside[slot] = in_addr;
        b_public[slot] = got;
        b_seen[slot] = now;
        b_valid[slot] = 1'b1;
        pub = got;
        return 1;
    endfunction

    function automatic t_result translate_header();
        t_result r;
        bit plain, found;
        logic [31:0] pub;
        plain = (i_hdr_words == 4'd5) && ((i_frag_field & ~snbe_pkg::DF_BIT) == 16'h0);
        r = '{snbe_pkg::VERDICT_PASS, i_src_addr, i_dst_addr, i_ident, i_frag_field, 16'h0};
        if (i_kind == 1'b0) begin
            if (!plain) return r;
            found = 0;
            for (int i = 0; i < NBIND; i++) begin
                if (b_valid[i] && b_inside[i] == i_src_addr) begin
                    b_seen[i] = i_now_ns;
                    pub = b_public[i];
                    found = 1;
                    break;
                end
            end
            if (!found && !bind_new(i_src_addr, i_now_ns, pub)) return r;
            return '{snbe_pkg::VERDICT_REWRITE, pub, i_dst_addr, 16'h0, snbe_pkg::DF_BIT,
                     calc_csum(4'd5, i_tos_val, i_total_length, 16'h0, snbe_pkg::DF_BIT,
                               i_ttl_val, i_proto_num, pub, i_dst_addr)};
        end
        if ((i_dst_addr & m_mask) != m_prefix) return r;
        r = '{snbe_pkg::VERDICT_DROP, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0};
        if (!plain) return r;
        for (int i = 0; i < NBIND; i++) begin
            if (b_valid[i] && b_public[i] == i_dst_addr) begin
                r = '{snbe_pkg::VERDICT_REDIRECT, i_src_addr, b_inside[i], i_ident,
                      i_frag_field,
                      calc_csum(i_hdr_words, i_tos_val, i_total_length, i_ident,
                                i_frag_field, i_ttl_val, i_proto_num, i_src_addr,
                                b_inside[i])};
                break;
            end
        end
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            m_prefix <= 32'h0;
            m_mask <= 32'h0;
            m_timeout <= snbe_pkg::TIMEOUT_RST;
            for (int i = 0; i < NBIND; i++) b_valid[i] = 1'b0;
            recl_q.delete();
            next_off = 32'd1;
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    snbe_pkg::REG_PREFIX:  m_prefix <= i_cfg_data[31:0];
                    snbe_pkg::REG_MASK:    m_mask <= i_cfg_data[31:0];
                    snbe_pkg::REG_TIMEOUT: m_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(translate_header());
            if (i_out_valid && i_out_ready) begin
                got = '{i_verdict, i_out_src, i_out_dst, i_out_ident, i_out_frag,
                        i_out_checksum};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h",
                             $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $realtime, exp_r, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// top of the source nat binding engine testbench: clock, reset, header stimulus and verdict
// depends on snbe_pkg, source_nat_binding_engine and snbe_tb_checker

module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = snbe_pkg::REG_PREFIX;
    logic [47:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [31:0] src_addr = '0, dst_addr = '0;
    logic [3:0]  hdr_words = 4'd5;
    logic [15:0] frag_field = '0, ident = '0, total_length = '0;
    logic [7:0]  proto_num = '0, ttl_val = '0, tos_val = '0;
    logic [63:0] now_ns = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  verdict;
    logic [31:0] out_src, out_dst;
    logic [15:0] out_ident, out_frag, out_checksum;
    int          errors, pending;
    int          cycles = 0;
    bit          no_idle = 1'b0;   // long stretch with both sides always ready
    logic [31:0] cur_prefix, cur_mask;
    logic [63:0] clock_ns = 64'd1000;
    logic [31:0] inside_pool [8];

    localparam int CYCLE_LIMIT = 1500000;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    source_nat_binding_engine u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_kind(kind), .i_src_addr(src_addr), .i_dst_addr(dst_addr),
        .i_hdr_words(hdr_words), .i_frag_field(frag_field), .i_ident(ident),
        .i_proto_num(proto_num), .i_ttl_val(ttl_val), .i_tos_val(tos_val),
        .i_total_length(total_length), .i_now_ns(now_ns),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_verdict(verdict),
        .o_out_src(out_src), .o_out_dst(out_dst), .o_out_ident(out_ident),
        .o_out_frag(out_frag), .o_out_checksum(out_checksum)
    );

    snbe_tb_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_kind(kind), .i_src_addr(src_addr), .i_dst_addr(dst_addr),
        .i_hdr_words(hdr_words), .i_frag_field(frag_field), .i_ident(ident),
        .i_proto_num(proto_num), .i_ttl_val(ttl_val), .i_tos_val(tos_val),
        .i_total_length(total_length), .i_now_ns(now_ns),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_verdict(verdict),
        .i_out_src(out_src), .i_out_dst(out_dst), .i_out_ident(out_ident),
        .i_out_frag(out_frag), .i_out_checksum(out_checksum),
        .o_errors(errors), .o_pending(pending)
    );

    // timeout watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // result side stalls about 21 percent of the time
    always @(posedge clk) begin
        out_ready <= no_idle || ($urandom_range(99) >= 21);
    end

    // write enable stays high across back-to-back writes, the caller drops it
    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // wait until every result is back, then let the worst-case walk time pass
    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    // one header transfer; valid is held until accepted, the block is busy the cycle after
    task automatic send_header(logic k, logic [31:0] s, logic [31:0] d, logic [3:0] ihl,
                               logic [15:0] fr, logic [63:0] t);
        @(posedge clk);
        while (!no_idle && $urandom_range(99) < 21) @(posedge clk);
        in_valid <= 1'b1;
        kind <= k;
        src_addr <= s;
        dst_addr <= d;
        hdr_words <= ihl;
        frag_field <= fr;
        ident <= 16'($urandom());
        proto_num <= 8'($urandom());
        ttl_val <= 8'($urandom());
        tos_val <= 8'($urandom());
        total_length <= 16'($urandom());
        now_ns <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        in_valid <= 1'b0;
    endtask

    // one random header, mostly well-formed and aimed at the pool and known inside hosts
    task automatic random_header();
        logic [31:0] s, d;
        logic [3:0]  ihl;
        logic [15:0] fr;
        logic        k;
        int          sel;
        sel = $urandom_range(99);
        k = $urandom_range(99) < 40;
        s = inside_pool[$urandom_range(7)];
        d = (cur_prefix & cur_mask) | ($urandom() & ~cur_mask & 32'h7);
        ihl = 4'd5;
        fr = $urandom_range(1) ? snbe_pkg::DF_BIT : 16'h0;
        if (sel < 12) begin
            s = $urandom();
            d = $urandom();
        end else if (sel < 20) begin
            ihl = 4'($urandom());
            fr = 16'($urandom());
        end
        if (k) s = $urandom();
        clock_ns = clock_ns + ($urandom_range(9) == 0 ? 64'd5000
                                                      : 64'($urandom_range(40)));
        send_header(k, s, d, ihl, fr, $urandom_range(49) == 0 ? {$urandom(), $urandom()}
                                                              : clock_ns);
    endtask

    task automatic set_pool(logic [31:0] pfx, logic [31:0] msk, logic [47:0] tmo);
        cur_prefix = pfx;
        cur_mask = msk;
        write_reg(snbe_pkg::REG_PREFIX, {16'h0, pfx});
        write_reg(snbe_pkg::REG_MASK, {16'h0, msk});
        write_reg(snbe_pkg::REG_TIMEOUT, tmo);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [31:0] pfx;
        for (int i = 0; i < 8; i++) inside_pool[i] = 32'h0a000000 | $urandom_range(4095);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default config, a zero prefix hits candidate below limit only in edge
        send_header(1'b0, 32'h0a000001, 32'h08080808, 4'd5, 16'h0, 64'd10);
        drain();
        // tiny pool of /29: a few allocations, exhaustion, eviction, reclaim
        set_pool(32'hc6336400, 32'hfffffff8, 48'd100);
        for (int i = 0; i < 6; i++)
            send_header(1'b0, 32'h0a000010 + i, 32'hffffffff, 4'd5, snbe_pkg::DF_BIT, 64'd0);
        send_header(1'b0, 32'h0a000010, 32'h0, 4'd5, 16'h0, 64'd50);          // hit
        send_header(1'b1, 32'h01020304, 32'hc6336401, 4'd5, 16'h0, 64'd60);   // no binding
        send_header(1'b1, 32'h01020304, 32'hc6336406, 4'd5, 16'h0, 64'd60);   // no binding
        send_header(1'b1, 32'h01020304, 32'hc6336401, 4'd6, 16'h0, 64'd60);   // options drop
        send_header(1'b1, 32'h01020304, 32'h09000001, 4'd5, 16'h0, 64'd60);   // outside pool
        send_header(1'b0, 32'h0a000011, 32'h0, 4'd15, 16'h0, 64'd60);         // options pass
        send_header(1'b0, 32'h0a000011, 32'h0, 4'd5, 16'hbfff, 64'd60);       // fragment
        send_header(1'b0, 32'h0a000099, 32'h0, 4'd5, 16'h0, 64'd500);         // evict
        send_header(1'b0, 32'h0a00009a, 32'h0, 4'd5, 16'h0, 64'd500);
        send_header(1'b0, 32'h0a00009b, 32'h0, 4'd5, 16'hffff, 64'hffffffffffffffff);
        send_header(1'b1, 32'hffffffff, 32'hc6336402, 4'd0, 16'h4000,
                    64'hffffffffffffffff);
        drain();
        // extremes of the registers
        set_pool(32'hffffffff, 32'hffffffff, 48'hffffffffffff);
        send_header(1'b0, 32'h0, 32'h0, 4'd5, 16'h0, 64'd1);
        send_header(1'b1, 32'h0, 32'hffffffff, 4'd5, 16'h0, 64'd1);
        drain();

        // random phases over several pool sizes
        for (int ph = 0; ph < 6; ph++) begin
            pfx = {8'd100 + ph[7:0], 8'($urandom_range(255)), 8'($urandom_range(255)), 8'h0};
            case (ph)
                0: set_pool(pfx, 32'hfffffff0, 48'd2000);
                1: set_pool(pfx, 32'hffffff80, 48'd0);
                2: set_pool(pfx, 32'hffffffc0, 48'd20000);
                3: set_pool(32'h0, 32'h0, 48'd300);
                4: set_pool(pfx, 32'hfffffffc, 48'd50);
                default: set_pool(pfx, 32'hffffffe0, 48'd1000);
            endcase
            for (int i = 0; i < 8; i++)
                inside_pool[i] = 32'h0a000000 | ($urandom_range(4095) << ph);
            no_idle = (ph == 2);
            for (int n = 0; n < 280; n++) random_header();
            no_idle = 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
